// File: hdl/assert_macros.svh
// Assertion shorthands used by the top-level translator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/dgat_pkg.sv
package dgat_pkg;

  localparam int unsigned CYL_W     = 12;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LIN_W     = 28;
  localparam int unsigned PER_CYL_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CYL_W-1:0]     RESET_CYLINDERS = 12'd815;
  localparam logic [BYTE_W-1:0]    RESET_HEADS     = 8'd19;
  localparam logic [BYTE_W-1:0]    RESET_BLOCKS    = 8'd17;
  localparam logic [PER_CYL_W-1:0] RESET_PER_CYL   = 16'd323;
  localparam logic [LIN_W-1:0]     RESET_TOTAL     = 28'd263245;

  typedef enum logic {
    CMD_CHS_TO_LBA = 1'b0,
    CMD_LBA_TO_CHS = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    NEXT_SAME_TRACK  = 2'd0,
    NEXT_HEAD        = 2'd1,
    NEXT_CYLINDER    = 2'd2,
    NEXT_END_OF_PACK = 2'd3
  } next_code_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CYLINDER_COUNT   = 2'd0,
    REG_HEAD_COUNT       = 2'd1,
    REG_BLOCKS_PER_TRACK = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CYL_W-1:0]  cyl_count;
    logic [BYTE_W-1:0] head_count;
    logic [BYTE_W-1:0] blocks;
  } geom_t;

  // Item fields as they travel down the pipeline.
  typedef struct packed {
    cmd_e              cmd;
    logic [CYL_W-1:0]  cyl;
    logic [BYTE_W-1:0] head;
    logic [BYTE_W-1:0] blk;
    logic [LIN_W-1:0]  lin;
  } in_beat_t;

  // Sideband carried alongside the first divider.
  typedef struct packed {
    cmd_e              cmd;
    logic [CYL_W-1:0]  cyl;
    logic [BYTE_W-1:0] head;
    logic [BYTE_W-1:0] blk;
    logic [LIN_W-1:0]  lin;
    logic              bad;
  } side_t;

  // Sideband carried alongside the second divider.
  typedef struct packed {
    side_t            base;
    logic [LIN_W-1:0] quo_cyl;
  } side2_t;

  typedef struct packed {
    logic [31:0]       header_word;
    logic [BYTE_W-1:0] out_block;
    logic [BYTE_W-1:0] out_head;
    logic [CYL_W-1:0]  out_cylinder;
    logic [LIN_W-1:0]  out_linear;
    logic              out_of_range;
  } result_t;

endpackage

// File: hdl/dgat_div_pipe.sv
// Restoring divider, one quotient bit per pipeline stage.
module dgat_div_pipe #(
  parameter int unsigned NUM_W  = 28,
  parameter int unsigned DEN_W  = 16,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quo_o,
  output logic [DEN_W-1:0]  rem_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              vld_q  [NUM_W];
  logic [NUM_W-1:0]  work_q [NUM_W];
  logic [DEN_W-1:0]  rem_q  [NUM_W];
  logic [DEN_W-1:0]  den_q  [NUM_W];
  logic [SIDE_W-1:0] side_q [NUM_W];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic              vld_in;
    logic [NUM_W-1:0]  work_in;
    logic [DEN_W-1:0]  rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              take;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign work_in = num_i;
      assign rem_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign work_in = work_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    // The numerator's top bit shifts into the partial remainder; the
    // quotient bit shifts in at the bottom of the same word.
    assign trial = {rem_in, work_in[NUM_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign take  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        work_q[s] <= {work_in[NUM_W-2:0], take};
        rem_q[s]  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[NUM_W-1];
  assign quo_o   = work_q[NUM_W-1];
  assign rem_o   = rem_q[NUM_W-1];
  assign side_o  = side_q[NUM_W-1];

endmodule

// File: hdl/dgat_out_stage.sv
// Picks the final triple, builds the sector header word and holds the result.
module dgat_out_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  dgat_pkg::side2_t           side_i,
  input  logic [dgat_pkg::BYTE_W-1:0] head_i,
  input  logic [dgat_pkg::BYTE_W-1:0] blk_i,
  input  dgat_pkg::geom_t            geom_i,
  output logic                       valid_o,
  output dgat_pkg::result_t          res_o
);

  logic                        valid_q;
  dgat_pkg::result_t           res_q;
  dgat_pkg::result_t           res_d;
  logic [dgat_pkg::LIN_W-1:0]  cyl;
  logic [dgat_pkg::BYTE_W-1:0] head;
  logic [dgat_pkg::BYTE_W-1:0] blk;
  logic                        geom_zero;
  logic [dgat_pkg::BYTE_W:0]   blk_next;
  logic [dgat_pkg::BYTE_W:0]   head_next;
  logic [dgat_pkg::LIN_W:0]    cyl_next;
  dgat_pkg::next_code_e        code;

  assign geom_zero = (geom_i.head_count == '0) || (geom_i.blocks == '0);

  always_comb begin
    if (side_i.base.cmd == dgat_pkg::CMD_CHS_TO_LBA) begin
      cyl  = dgat_pkg::LIN_W'(side_i.base.cyl);
      head = side_i.base.head;
      blk  = side_i.base.blk;
    end else if (geom_zero) begin
      cyl  = '0;
      head = '0;
      blk  = '0;
    end else begin
      cyl  = side_i.quo_cyl;
      head = head_i;
      blk  = blk_i;
    end
  end

  // The next-block code looks at the full quotient, not the masked cylinder.
  assign blk_next  = {1'b0, blk} + 1'b1;
  assign head_next = {1'b0, head} + 1'b1;
  assign cyl_next  = {1'b0, cyl} + 1'b1;

  always_comb begin
    if (blk_next < {1'b0, geom_i.blocks}) begin
      code = dgat_pkg::NEXT_SAME_TRACK;
    end else if (head_next < {1'b0, geom_i.head_count}) begin
      code = dgat_pkg::NEXT_HEAD;
    end else if (cyl_next < (dgat_pkg::LIN_W + 1)'(geom_i.cyl_count)) begin
      code = dgat_pkg::NEXT_CYLINDER;
    end else begin
      code = dgat_pkg::NEXT_END_OF_PACK;
    end
  end

  always_comb begin
    res_d.out_linear   = side_i.base.lin;
    res_d.out_cylinder = cyl[dgat_pkg::CYL_W-1:0];
    res_d.out_head     = head;
    res_d.out_block    = blk;
    res_d.header_word  = {code, 2'b00, cyl[dgat_pkg::CYL_W-1:0], head, blk};
    res_d.out_of_range = side_i.base.bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: hdl/disk_geometry_address_translate.sv
// Disk address translator for a pack of configurable geometry. A beat with
// tuser 0 carries a cylinder/head/block triple and returns the linear block
// number; a beat with tuser 1 carries a linear block number and returns the
// triple. Every result also carries the 32-bit sector header word and an
// out-of-range flag in tuser. The block takes one beat per clock unless the
// result side stalls, and returns the results in order. The pipeline is made
// of the two restoring dividers, which spend one pipeline stage on each
// quotient bit: 28 stages for the linear number over blocks per cylinder and
// 16 for the remainder over blocks per track, plus three front stages for
// the multiply, add and range checks and one output register. A stall on the
// result side freezes the whole pipeline, so input ready follows output
// ready. Geometry registers may be rewritten only while no beat is in
// flight; the write port never stalls.
module disk_geometry_address_translate (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Address beats.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata, low to high: in_cylinder[11:0], in_head[19:12], in_block[27:20],
  // in_linear[55:28].
  input  logic [55:0] s_axis_tdata_i,
  // tuser: cmd.
  input  logic        s_axis_tuser_i,
  // Result beats.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata, low to high: out_linear[27:0], out_cylinder[39:28],
  // out_head[47:40], out_block[55:48], header_word[87:56].
  output logic [87:0] m_axis_tdata_o,
  // tuser: out_of_range.
  output logic        m_axis_tuser_o,
  // Geometry register writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [dgat_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dgat_pkg::CYL_W-1:0]     cfg_data_i
);

  `include "assert_macros.svh"

  localparam int unsigned SIDE_W  = $bits(dgat_pkg::side_t);
  localparam int unsigned SIDE2_W = $bits(dgat_pkg::side2_t);

  dgat_pkg::geom_t                geom_q;
  logic [dgat_pkg::PER_CYL_W-1:0] per_cyl_q;
  logic [dgat_pkg::LIN_W-1:0]     total_q;
  logic                           geom_zero;
  logic                           en;
  logic                           s_fire;
  logic                           out_stall;

  // Front stages.
  logic                           v1_q, v2_q, v3_q;
  dgat_pkg::in_beat_t             s1_q;
  dgat_pkg::in_beat_t             s2_q;
  logic                           bad0_q;
  logic [dgat_pkg::LIN_W-1:0]     prod_c_q;
  logic [dgat_pkg::PER_CYL_W-1:0] prod_h_q;
  dgat_pkg::side_t                s3_d, s3_q;

  // Divider chain.
  logic                           d1_valid;
  logic [dgat_pkg::LIN_W-1:0]     d1_quo;
  logic [dgat_pkg::PER_CYL_W-1:0] d1_rem;
  logic [SIDE_W-1:0]              d1_side;
  dgat_pkg::side2_t               d2_side_in;
  logic                           d2_valid;
  logic [dgat_pkg::PER_CYL_W-1:0] d2_quo;
  logic [dgat_pkg::BYTE_W-1:0]    d2_rem;
  logic [SIDE2_W-1:0]             d2_side;

  logic                           out_valid;
  dgat_pkg::result_t              res;

  // The whole pipeline advances unless a finished result is being held.
  assign en              = !out_valid || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign s_fire          = s_axis_tvalid_i && en;
  assign cfg_ready_o     = 1'b1;

  // Geometry registers. Writes to an index past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q.cyl_count  <= dgat_pkg::RESET_CYLINDERS;
      geom_q.head_count <= dgat_pkg::RESET_HEADS;
      geom_q.blocks     <= dgat_pkg::RESET_BLOCKS;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dgat_pkg::REG_CYLINDER_COUNT:   geom_q.cyl_count  <= cfg_data_i;
        dgat_pkg::REG_HEAD_COUNT:       geom_q.head_count <= cfg_data_i[dgat_pkg::BYTE_W-1:0];
        dgat_pkg::REG_BLOCKS_PER_TRACK: geom_q.blocks     <= cfg_data_i[dgat_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Blocks per cylinder and pack size are registered products of the
  // geometry, pack size after blocks per cylinder. The user must keep the first
  // beat after a write back until they settle; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per_cyl_q <= dgat_pkg::RESET_PER_CYL;
      total_q   <= dgat_pkg::RESET_TOTAL;
    end else begin
      per_cyl_q <= dgat_pkg::PER_CYL_W'(geom_q.head_count) *
                   dgat_pkg::PER_CYL_W'(geom_q.blocks);
      total_q   <= dgat_pkg::LIN_W'(geom_q.cyl_count) * dgat_pkg::LIN_W'(per_cyl_q);
    end
  end

  assign geom_zero = (geom_q.head_count == '0) || (geom_q.blocks == '0);

  // Stage 1 registers the accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_fire;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q.cmd  <= dgat_pkg::cmd_e'(s_axis_tuser_i);
      s1_q.cyl  <= s_axis_tdata_i[11:0];
      s1_q.head <= s_axis_tdata_i[19:12];
      s1_q.blk  <= s_axis_tdata_i[27:20];
      s1_q.lin  <= s_axis_tdata_i[55:28];
    end
  end

  // Stage 2: the two products of the triple and its field checks.
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q     <= s1_q;
      prod_c_q <= dgat_pkg::LIN_W'(s1_q.cyl) * dgat_pkg::LIN_W'(per_cyl_q);
      prod_h_q <= dgat_pkg::PER_CYL_W'(s1_q.head) * dgat_pkg::PER_CYL_W'(geom_q.blocks);
      bad0_q   <= (s1_q.cyl >= geom_q.cyl_count) || (s1_q.head >= geom_q.head_count) ||
                  (s1_q.blk >= geom_q.blocks);
    end
  end

  // Stage 3: the linear number of a triple, or the pack-end check of a
  // linear number. A triple outside the geometry maps to block zero.
  always_comb begin
    s3_d.cmd  = s2_q.cmd;
    s3_d.cyl  = s2_q.cyl;
    s3_d.head = s2_q.head;
    s3_d.blk  = s2_q.blk;
    if (s2_q.cmd == dgat_pkg::CMD_CHS_TO_LBA) begin
      s3_d.lin = bad0_q ? '0
                        : prod_c_q + dgat_pkg::LIN_W'(prod_h_q) + dgat_pkg::LIN_W'(s2_q.blk);
      s3_d.bad = bad0_q;
    end else begin
      s3_d.lin = s2_q.lin;
      s3_d.bad = geom_zero || (s2_q.lin >= total_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q <= s3_d;
    end
  end

  // Cylinder is the quotient over blocks per cylinder.
  dgat_div_pipe #(
    .NUM_W  (dgat_pkg::LIN_W),
    .DEN_W  (dgat_pkg::PER_CYL_W),
    .SIDE_W (SIDE_W)
  ) u_div_cyl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .num_i   (s3_q.lin),
    .den_i   (per_cyl_q),
    .side_i  (s3_q),
    .valid_o (d1_valid),
    .quo_o   (d1_quo),
    .rem_o   (d1_rem),
    .side_o  (d1_side)
  );

  assign d2_side_in.base    = dgat_pkg::side_t'(d1_side);
  assign d2_side_in.quo_cyl = d1_quo;

  // Head and block are the quotient and remainder of what is left over
  // blocks per track.
  dgat_div_pipe #(
    .NUM_W  (dgat_pkg::PER_CYL_W),
    .DEN_W  (dgat_pkg::BYTE_W),
    .SIDE_W (SIDE2_W)
  ) u_div_head (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d1_valid),
    .num_i   (d1_rem),
    .den_i   (geom_q.blocks),
    .side_i  (d2_side_in),
    .valid_o (d2_valid),
    .quo_o   (d2_quo),
    .rem_o   (d2_rem),
    .side_o  (d2_side)
  );

  dgat_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d2_valid),
    .side_i  (dgat_pkg::side2_t'(d2_side)),
    .head_i  (d2_quo[dgat_pkg::BYTE_W-1:0]),
    .blk_i   (d2_rem),
    .geom_i  (geom_q),
    .valid_o (out_valid),
    .res_o   (res)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = {res.header_word, res.out_block, res.out_head,
                            res.out_cylinder, res.out_linear};
  assign m_axis_tuser_o  = res.out_of_range;

  // A result is on offer but is not taken in this cycle.
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;

  // An accepted beat always occupies the first stage on the next cycle.
  `ASSERT_NXT(a_accept_lands, clk_i, rst_ni, s_fire, v1_q)
  // A held result freezes the front stages.
  `ASSERT_NXT(a_stall_freezes, clk_i, rst_ni, out_stall, $stable({v1_q, v2_q, v3_q}))
  // No beat enters while a result is held.
  `ASSERT_IMP(a_no_entry_on_stall, clk_i, rst_ni, out_stall, !s_axis_tready_o)

endmodule
